// ===== src/ccr_pkg.sv =====
// ccr_pkg: shared types and constants for the clock replacement directory
// no dependencies; imported by ccr_seq and clock_cache_replacement_core
`default_nettype none

package ccr_pkg;

  localparam int KEY_W  = 32;
  localparam int SLOT_W = 2;

  // one finished result as it leaves the sequencer
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              ev_valid;
    logic [KEY_W-1:0]  ev_key;
  } result_t;

endpackage

`default_nettype wire

// ===== src/ccr_ram.sv =====
// ccr_ram: generic single write port, single read port ram with registered read
// no dependencies; used for the slot key store
`default_nettype none

module ccr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/ccr_seq.sv =====
// ccr_seq: sequencer for lookup, fill, clock sweep and eviction
// depends on ccr_pkg and ccr_ram; one key compare per cycle against the ram
`default_nettype none

module ccr_seq
  import ccr_pkg::*;
#(
  parameter int CACHE_SLOTS = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [KEY_W-1:0] key,
  output logic                  res_valid,
  input  wire logic             res_take,
  output result_t               res
);

  localparam int IDX_W = (CACHE_SLOTS > 1) ? $clog2(CACHE_SLOTS) : 1;
  localparam int CNT_W = $clog2(CACHE_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_SLOTS - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CACHE_SLOTS);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_SWEEP = 3'd2;
  localparam logic [2:0] S_EVICT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]             state;
  logic [KEY_W-1:0]       key_r;
  logic [CNT_W-1:0]       idx;
  logic [IDX_W-1:0]       cmp_idx;
  logic                   cmp_valid;
  logic [CNT_W-1:0]       occ;
  logic [IDX_W-1:0]       hand;
  logic [IDX_W-1:0]       h;
  logic [CACHE_SLOTS-1:0] refb;

  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [IDX_W-1:0]       raddr;
  logic [KEY_W-1:0]       rdata;
  logic                   match;
  logic                   more;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] v);
    return (v == LAST_IDX) ? '0 : v + 1'b1;
  endfunction

  ccr_ram #(.WIDTH(KEY_W), .DEPTH(CACHE_SLOTS)) u_keys (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (key_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  // shared compare unit: one stored key against the request per cycle
  assign match = cmp_valid && (rdata == key_r);
  assign more  = idx < occ;

  assign in_stall  = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  // ram read address: scan index during lookup, sweep position h otherwise
  always_comb begin
    raddr = h;
    if (state == S_LOOK) begin
      raddr = idx[IDX_W-1:0];
    end
  end

  // ram write: fill at the hand, or replace the victim
  always_comb begin
    we    = 1'b0;
    waddr = hand;
    if (state == S_LOOK && !match && !more && occ != FULL_CNT) begin
      we = 1'b1;
    end else if (state == S_EVICT) begin
      we    = 1'b1;
      waddr = h;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      occ       <= '0;
      hand      <= '0;
      refb      <= '0;
      cmp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cmp_valid <= 1'b0;
          if (in_valid) begin
            state <= S_LOOK;
          end
        end
        S_LOOK: begin
          if (match) begin
            refb[cmp_idx] <= 1'b1;
            state         <= S_DONE;
          end else if (more) begin
            cmp_valid <= 1'b1;
          end else if (occ != FULL_CNT) begin
            refb[hand] <= 1'b0;
            occ        <= occ + 1'b1;
            hand       <= adv(hand);
            state      <= S_DONE;
          end else begin
            state <= S_SWEEP;
          end
        end
        S_SWEEP: begin
          if (refb[h]) begin
            refb[h] <= 1'b0;
          end else begin
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          refb[h] <= 1'b0;
          hand    <= adv(h);
          state   <= S_DONE;
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        key_r <= key;
        idx   <= '0;
      end
      S_LOOK: begin
        if (match) begin
          res.hit      <= 1'b1;
          res.slot     <= SLOT_W'(cmp_idx);
          res.ev_valid <= 1'b0;
          res.ev_key   <= '0;
        end else if (more) begin
          cmp_idx <= idx[IDX_W-1:0];
          idx     <= idx + 1'b1;
        end else begin
          res.hit      <= 1'b0;
          res.slot     <= SLOT_W'(hand);
          res.ev_valid <= 1'b0;
          res.ev_key   <= '0;
          h            <= hand;
        end
      end
      S_SWEEP: begin
        if (refb[h]) begin
          h <= adv(h);
        end
      end
      S_EVICT: begin
        res.hit      <= 1'b0;
        res.slot     <= SLOT_W'(h);
        res.ev_valid <= 1'b1;
        res.ev_key   <= rdata;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/clock_cache_replacement_core.sv =====
// clock_cache_replacement_core: top level of the clock replacement directory
// depends on ccr_pkg and ccr_seq; holds the output register
//
// usage: one key per input transaction on in_valid/in_stall/key; one result per
// transaction on out_valid/out_stall with hit, slot, evicted_valid, evicted_key.
// a hit sets the slot's reference bit; a miss fills the slot at the clock hand
// or, when full, sweeps the hand clearing reference bits and evicts the first
// slot whose bit is clear.
// the lookup reads one stored key per cycle from the key ram and feeds the
// single comparator; a full-cache miss then sweeps and reads the victim key;
// every transaction also passes through an accept state and a result state.
// in_stall is high while a transaction is in progress; one item at a time.
// the result sits in an output register; while out_stall is high it holds and
// the sequencer waits, so a new key is taken once the result has moved into it.
// reset clears the reference bits, fill count and hand; stored keys are
// unknown until filled and are never compared before then.
`default_nettype none

module clock_cache_replacement_core
  import ccr_pkg::*;
#(
  parameter int CACHE_SLOTS = 4
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [KEY_W-1:0]  key,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   hit,
  output logic      [SLOT_W-1:0] slot,
  output logic                   evicted_valid,
  output logic      [KEY_W-1:0]  evicted_key
);

  logic    res_valid;
  logic    res_take;
  result_t res;
  result_t out_r;

  ccr_seq #(.CACHE_SLOTS(CACHE_SLOTS)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .key       (key),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  // load the output register when it is empty or being drained
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign hit           = out_r.hit;
  assign slot          = out_r.slot;
  assign evicted_valid = out_r.ev_valid;
  assign evicted_key   = out_r.ev_key;

endmodule

`default_nettype wire
